// ----- hw/rtl/i2c_master_bit_sequencer_defines.svh -----
// Assertion macros for the I2C master bit sequencer checker.
// Depends on nothing; included by the checker file only.
`ifndef I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define I2CMS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: label failed");

// Next-cycle implication, disabled while rst is high.
`define I2CMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: label failed");

`endif

// ----- hw/rtl/i2cms_pkg.sv -----
// Shared types and constants of the I2C master bit sequencer.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package i2cms_pkg;

   typedef enum logic [2:0] {
      OP_IDLE         = 3'd0,
      OP_START        = 3'd1,
      OP_STOP         = 3'd2,
      OP_WRITE        = 3'd3,
      OP_WAIT         = 3'd4,
      OP_READ         = 3'd5,
      OP_TIMEOUT_STOP = 3'd6
   } op_type;

   // command codes on the input word
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_READ  = 3'd5;

   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

   localparam logic [4:0] WRITE_END_PHASE = 5'd24;
   localparam logic [4:0] READ_ACK_PHASE  = 5'd16;
   localparam logic [4:0] READ_CLK_PHASE  = 5'd17;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] write_byte;
      logic       send_ack;
      logic       sda_sample;
   } item_type;

   // scl_level ends up in bit 0
   typedef struct packed {
      logic       ack_missing;
      logic [7:0] read_byte;
      logic       done_res;
      logic       busy_res;
      logic       sda_level;
      logic       scl_level;
   } result_type;

   localparam int RESULT_BITS = $bits(result_type);

endpackage

`default_nettype wire

// ----- hw/rtl/i2cms_in_stage.sv -----
// Input register of the I2C master bit sequencer: holds one request word.
// Depends on i2cms_pkg.
`default_nettype none

module i2cms_in_stage
   import i2cms_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,
   input  wire logic [2:0]  req_tuser,
   input  wire logic        step,
   output      logic        item_valid,
   output      item_type    item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   // free when empty or when the held word moves on this cycle
   assign req_tready = !valid_ff || step;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         item_in.cmd        = req_tuser;
         item_in.write_byte = req_tdata[7:0];
         item_in.send_ack   = req_tdata[8];
         item_in.sda_sample = req_tdata[9];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/i2cms_engine.sv -----
// Line sequencing state machine: one tick per word, SCL/SDA drive levels.
// Depends on i2cms_pkg; holds the ack timeout register.
`default_nettype none

module i2cms_engine
   import i2cms_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_valid,
   input  wire logic [7:0] csr_data,
   input  wire logic       step,
   input  wire item_type   item,
   output      result_type result
);

   op_type     op_ff, op_in;
   logic [4:0] phase_ff, phase_in;
   logic [1:0] sub_ff, sub_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] wait_ff, wait_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       ack_ff, ack_in;
   logic       nack_ff, nack_in;
   logic [7:0] rx_ff, rx_in;
   logic [7:0] timeout_ff;
   logic       done;

   always_comb begin
      logic   advance;
      logic   run;
      advance  = 1'b1;
      run      = 1'b0;
      op_in    = op_ff;
      phase_in = phase_ff;
      sub_in   = sub_ff;
      shift_in = shift_ff;
      wait_in  = wait_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      ack_in   = ack_ff;
      nack_in  = nack_ff;
      rx_in    = rx_ff;
      done     = 1'b0;

      if (op_ff == OP_IDLE) begin
         // latch a new command; unknown codes and none leave the block idle
         if (item.cmd >= CMD_START && item.cmd <= CMD_READ) begin
            op_in    = op_type'(item.cmd);
            phase_in = 5'd0;
            sub_in   = 2'd0;
            wait_in  = 8'd0;
            run      = 1'b1;
            if (op_type'(item.cmd) == OP_WRITE) begin
               shift_in = item.write_byte;
            end
            if (op_type'(item.cmd) == OP_READ) begin
               shift_in = 8'd0;
               ack_in   = item.send_ack;
            end
         end
      end else begin
         run = 1'b1;
      end

      if (run) begin
         case (op_in)
            OP_START: begin
               if (phase_in == 5'd0) begin
                  sda_in = 1'b1;
                  scl_in = 1'b1;
               end else if (phase_in == 5'd1) begin
                  sda_in = 1'b0;
               end else begin
                  scl_in = 1'b0;
                  done   = 1'b1;
               end
            end
            OP_STOP, OP_TIMEOUT_STOP: begin
               if (phase_in == 5'd0) begin
                  scl_in = 1'b0;
                  sda_in = 1'b0;
               end else if (phase_in == 5'd1) begin
                  scl_in = 1'b1;
               end else if (phase_in == 5'd2) begin
                  sda_in = 1'b1;
               end else begin
                  nack_in = (op_in == OP_TIMEOUT_STOP);
                  done    = 1'b1;
               end
            end
            OP_WRITE: begin
               if (phase_in >= WRITE_END_PHASE) begin
                  done = 1'b1;
               end else begin
                  // sub counts the phase modulo three
                  case (sub_in)
                     2'd0: begin
                        if (phase_in == 5'd0) begin
                           scl_in = 1'b0;
                        end
                        sda_in   = shift_in[7];
                        shift_in = {shift_in[6:0], 1'b0};
                     end
                     2'd1: begin
                        scl_in = 1'b1;
                     end
                     default: begin
                        scl_in = 1'b0;
                     end
                  endcase
                  sub_in = (sub_in == 2'd2) ? 2'd0 : sub_in + 2'd1;
               end
            end
            OP_WAIT: begin
               if (phase_in == 5'd0) begin
                  sda_in = 1'b1;
               end else if (phase_in == 5'd1) begin
                  scl_in = 1'b1;
               end else begin
                  // poll: phase holds while waiting
                  advance = 1'b0;
                  if (!item.sda_sample) begin
                     scl_in  = 1'b0;
                     nack_in = 1'b0;
                     done    = 1'b1;
                  end else if (wait_in >= timeout_ff) begin
                     op_in    = OP_TIMEOUT_STOP;
                     phase_in = 5'd0;
                     scl_in   = 1'b0;
                     sda_in   = 1'b0;
                  end else begin
                     wait_in = wait_in + 8'd1;
                  end
               end
            end
            OP_READ: begin
               if (phase_in == 5'd0) begin
                  sda_in = 1'b1;
                  scl_in = 1'b0;
               end else if (phase_in < READ_ACK_PHASE) begin
                  if (phase_in[0]) begin
                     scl_in   = 1'b1;
                     shift_in = {shift_in[6:0], item.sda_sample};
                  end else begin
                     scl_in = 1'b0;
                  end
               end else if (phase_in == READ_ACK_PHASE) begin
                  scl_in = 1'b0;
                  sda_in = !ack_in;
               end else if (phase_in == READ_CLK_PHASE) begin
                  scl_in = 1'b1;
               end else begin
                  scl_in = 1'b0;
                  rx_in  = shift_in;
                  done   = 1'b1;
               end
            end
            default: begin
               done = 1'b1;
            end
         endcase
         if (advance && !done) begin
            phase_in = phase_in + 5'd1;
         end
         if (done) begin
            op_in = OP_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff      <= OP_IDLE;
         phase_ff   <= 5'd0;
         sub_ff     <= 2'd0;
         shift_ff   <= 8'd0;
         wait_ff    <= 8'd0;
         scl_ff     <= 1'b1;
         sda_ff     <= 1'b1;
         ack_ff     <= 1'b0;
         nack_ff    <= 1'b0;
         rx_ff      <= 8'd0;
         timeout_ff <= ACK_TIMEOUT_RESET;
      end else begin
         if (step) begin
            op_ff    <= op_in;
            phase_ff <= phase_in;
            sub_ff   <= sub_in;
            shift_ff <= shift_in;
            wait_ff  <= wait_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
            ack_ff   <= ack_in;
            nack_ff  <= nack_in;
            rx_ff    <= rx_in;
         end
         if (csr_valid) begin
            timeout_ff <= csr_data;
         end
      end
   end

   always_comb begin
      result.scl_level   = scl_in;
      result.sda_level   = sda_in;
      result.busy_res    = (op_in != OP_IDLE);
      result.done_res    = done;
      result.read_byte   = rx_in;
      result.ack_missing = nack_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/i2cms_out_stage.sv -----
// Result register of the I2C master bit sequencer: holds one response word.
// Depends on i2cms_pkg.
`default_nettype none

module i2cms_out_stage
   import i2cms_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire result_type  result,
   output      logic        space,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign space = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (space) begin
         valid_in = step;
      end
      if (step) begin
         data_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(16 - RESULT_BITS){1'b0}}, data_ff};

endmodule

`default_nettype wire

// ----- hw/rtl/i2c_master_bit_sequencer.sv -----
// I2C master bit sequencer: one request word per bus tick, one response word each.
// A request word is held in the input register, then its result is held in the result register.
// Throughput: one word per cycle while rsp_tready does not stall, set by the input and result registers.
// Synchronous active-high reset: SCL and SDA released, idle, timeout 250.
// Depends on i2cms_pkg, i2cms_in_stage, i2cms_engine, i2cms_out_stage.
`default_nettype none

module i2c_master_bit_sequencer
   import i2cms_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [7:0]  csr_data,    // ack_timeout
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,   // write_byte[7:0], send_ack[8], sda_sample[9]
   input  wire logic [2:0]  req_tuser,   // cmd[2:0]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata    // scl_level[0], sda_level[1], busy_res[2],
                                         // done_res[3], read_byte[11:4], ack_missing[12]
);

   item_type   item;
   result_type result;
   logic       item_valid;
   logic       space;
   logic       step;

   assign csr_ready = 1'b1;
   assign step      = item_valid && space;

   i2cms_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .step       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   i2cms_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .step      (step),
      .item      (item),
      .result    (result)
   );

   i2cms_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .result     (result),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/i2cms_checker.sv -----
// Port-level checker for the I2C master bit sequencer, bound to the top level.
// Depends on i2c_master_bit_sequencer_defines.svh.
`default_nettype none

`include "i2c_master_bit_sequencer_defines.svh"

module i2cms_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   // a stalled response word holds
   `I2CMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // no response word right after reset
   `I2CMS_ASSERT_IMPLY(a_rsp_reset, clock, 1'b0, $past(reset), !rsp_tvalid)

   // a taken request word reaches the result register once the sink is ready
   `I2CMS_ASSERT_NEXT(a_req_to_rsp, clock, reset, $past(req_tvalid && req_tready) && !$past(reset) && rsp_tready, rsp_tvalid)

   // a finishing word never reports busy
   `I2CMS_ASSERT_IMPLY(a_done_idle, clock, reset, rsp_tvalid && rsp_tdata[3], !rsp_tdata[2])

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
